FILE: hw/rtl/periodic_task_dispatcher_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task dispatcher
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_UNIT_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_UNIT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, widths and codes of the periodic task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int unsigned NUM_TASKS_DEF   = 8;
  localparam int unsigned PERIOD_BITS_DEF = 16;
  localparam int unsigned MAX_SLOTS       = 8;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned PERIOD_IN_W = 16;
  localparam int unsigned HZ_W        = 16;
  localparam int unsigned TC_W        = 4;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned EIDX_W      = 3;
  localparam int unsigned TIDX_W      = 3;
  localparam int unsigned MS_W        = 10;
  localparam int unsigned PROD_W      = TICK_W + MS_W;
  localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_HZ    = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_CLEAR = 2'd3
  } ptd_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_USTART,
    S_UWAIT,
    S_SCAN,
    S_PUSH,
    S_REARM,
    S_RWAIT,
    S_FINAL
  } ptd_state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic udiv_start;
    logic ms_latch;
    logic scan_inc;
    logic push;
    logic rdiv_start;
    logic rearm_zero;
    logic rearm_div;
    logic final_emit;
  } ptd_cmd_t;

  typedef struct packed {
    ptd_kind_e kind;
    logic      scan_end;
    logic      entry_due;
    logic      per_zero;
    logic      pend_valid;
    logic      div_done;
    logic      out_free;
  } ptd_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptd_if.sv
// ----------------------------------------------------------------------------
// ptd_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_in_if import ptd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [EIDX_W-1:0]      entry_index;
  logic [PERIOD_IN_W-1:0] entry_period;
  logic                   entry_active;

  modport source (output valid, kind, entry_index, entry_period, entry_active,
                  input ready);
  modport sink   (input valid, kind, entry_index, entry_period, entry_active,
                  output ready);
endinterface

interface ptd_out_if import ptd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              due_valid;
  logic [TIDX_W-1:0] task_index;
  logic              last;
  logic [TICK_W-1:0] msec_up;
  logic [TICK_W-1:0] uptime_ticks;

  modport source (output valid, due_valid, task_index, last, msec_up, uptime_ticks,
                  input ready);
  modport sink   (input valid, due_valid, task_index, last, msec_up, uptime_ticks,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ptd_div.sv
// ----------------------------------------------------------------------------
// ptd_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_task_dispatcher_unit_macros.svh"

module ptd_div import ptd_pkg::*; #(
  parameter int unsigned DVD_W = PROD_W,
  parameter int unsigned DVS_W = PERIOD_IN_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quot_o,
  output logic [DVS_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] a_q, a_d;
  logic [DVS_W-1:0] r_q, r_d;
  logic [DVS_W-1:0] d_q, d_d;
  logic [DVS_W+1:0] trial;

  assign trial = {1'b0, r_q, a_q[DVD_W-1]} - {2'b00, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
    end else if (busy_q) begin
      // keep the difference when the trial subtract does not borrow
      if (!trial[DVS_W+1]) begin
        r_d = trial[DVS_W-1:0];
        a_d = {a_q[DVD_W-2:0], 1'b1};
      end else begin
        r_d = {r_q[DVS_W-2:0], a_q[DVD_W-1]};
        a_d = {a_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = a_q;
  assign rem_o  = r_q;

  `PTD_ASSERT(a_div_start_idle, start_i |-> !busy_q, "divider started while busy")
  `PTD_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q && !busy_q, "done not a single pulse")

endmodule

`default_nettype wire

FILE: hw/rtl/ptd_datapath.sv
// ----------------------------------------------------------------------------
// ptd_datapath
// Tick counter, task table, uptime conversion and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_task_dispatcher_unit_macros.svh"

module ptd_datapath import ptd_pkg::*; #(
  parameter int unsigned NUM_TASKS   = NUM_TASKS_DEF,
  parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [KIND_W-1:0]      in_kind_i,
  input  wire logic [EIDX_W-1:0]      in_entry_index_i,
  input  wire logic [PERIOD_IN_W-1:0] in_entry_period_i,
  input  wire logic                   in_entry_active_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire ptd_cmd_t               cmd_i,
  output ptd_sts_t                    sts_o,
  ptd_out_if.source                   out_o
);

  // entries past the eighth are never examined and a load can only reach 0..SLOTS-1
  localparam int unsigned SLOTS  = (NUM_TASKS < MAX_SLOTS) ? NUM_TASKS : MAX_SLOTS;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SCAN_W = $clog2(SLOTS + 1);
  localparam int unsigned PW     = (PERIOD_BITS < PERIOD_IN_W) ? PERIOD_BITS : PERIOD_IN_W;

  logic [TICK_W-1:0] ticks_q;
  logic [TICK_W-1:0] dl_q  [SLOTS];
  logic [PW-1:0]     per_q [SLOTS];
  logic [SLOTS-1:0]  act_q;

  logic [TC_W-1:0]   scan_limit_q;
  logic [HZ_W-1:0]   tick_hz_q;
  ptd_kind_e         kind_q;
  logic [PROD_W-1:0] prod_q;
  logic [TICK_W-1:0] ms_q;
  logic [SCAN_W-1:0] scan_q;
  logic              pend_valid_q;
  logic [IDX_W-1:0]  pend_idx_q;

  logic              out_valid_q, out_valid_d;
  logic              out_due_q, out_due_d;
  logic [TIDX_W-1:0] out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  logic [TICK_W-1:0] out_ms_q;
  logic [TICK_W-1:0] out_ticks_q;

  logic [IDX_W-1:0]       cur;
  logic [SCAN_W-1:0]      lim;
  logic [TICK_W-1:0]      delta;
  logic [TICK_W-1:0]      rearm_val;
  logic [PROD_W-1:0]      ticks_ext;
  logic                   load_ok;
  logic                   out_free;
  logic                   out_load;
  logic                   div_start;
  logic [PROD_W-1:0]      div_dvd;
  logic [PERIOD_IN_W-1:0] div_dvs;
  logic                   div_done;
  logic [PROD_W-1:0]      div_quot;
  logic [PERIOD_IN_W-1:0] div_rem;

  assign cur       = scan_q[IDX_W-1:0];
  assign lim       = (scan_limit_q > TC_W'(SLOTS)) ? SCAN_W'(SLOTS)
                                                   : SCAN_W'(scan_limit_q);
  assign delta     = ticks_q - dl_q[cur];
  // catch-up in closed form: now - (delta mod p) + p
  assign rearm_val = ticks_q - TICK_W'(div_rem) + TICK_W'(per_q[cur]);
  assign ticks_ext = PROD_W'(ticks_q);
  assign load_ok   = ({1'b0, in_entry_index_i} < (EIDX_W + 1)'(SLOTS));
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_load  = (cmd_i.push && pend_valid_q) || cmd_i.final_emit;

  // shared divider: uptime conversion, then remainders for re-arming
  assign div_start = cmd_i.udiv_start || cmd_i.rdiv_start;
  assign div_dvd   = cmd_i.udiv_start ? prod_q : PROD_W'(delta[TICK_W-2:0]);
  assign div_dvs   = cmd_i.udiv_start ? tick_hz_q : PERIOD_IN_W'(per_q[cur]);

  ptd_div #(
    .DVD_W (PROD_W),
    .DVS_W (PERIOD_IN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.scan_end   = (scan_q >= lim);
    sts_o.entry_due  = act_q[cur] && !delta[TICK_W-1];
    sts_o.per_zero   = (per_q[cur] == '0);
    sts_o.pend_valid = pend_valid_q;
    sts_o.div_done   = div_done;
    sts_o.out_free   = out_free;
  end

  // tick counter and task table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      act_q   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        dl_q[i]  <= '0;
        per_q[i] <= '0;
      end
    end else begin
      if (cmd_i.accept) begin
        case (ptd_kind_e'(in_kind_i))
          KIND_TICK: begin
            ticks_q <= ticks_q + TICK_W'(1);
          end
          KIND_LOAD: begin
            if (load_ok) begin
              per_q[in_entry_index_i[IDX_W-1:0]] <= in_entry_period_i[PW-1:0];
              act_q[in_entry_index_i[IDX_W-1:0]] <= in_entry_active_i;
              dl_q[in_entry_index_i[IDX_W-1:0]]  <=
                ticks_q + TICK_W'(in_entry_period_i[PW-1:0]);
            end
          end
          KIND_CLEAR: begin
            ticks_q <= '0;
            act_q   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
              dl_q[i]  <= '0;
              per_q[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.rearm_zero) begin
        dl_q[cur] <= ticks_q + TICK_W'(1);
      end
      if (cmd_i.rearm_div) begin
        dl_q[cur] <= rearm_val;
      end
    end
  end

  // configuration, item kind, scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= '0;
      tick_hz_q    <= '0;
      kind_q       <= KIND_TICK;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SCAN_LIMIT: scan_limit_q <= cfg_wdata_i[TC_W-1:0];
          CFG_TICK_HZ:    tick_hz_q    <= cfg_wdata_i[HZ_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.accept) begin
        kind_q       <= ptd_kind_e'(in_kind_i);
        scan_q       <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.scan_inc || cmd_i.rearm_zero || cmd_i.rearm_div) begin
        scan_q <= scan_q + SCAN_W'(1);
      end
      if (cmd_i.push) begin
        pend_valid_q <= 1'b1;
        pend_idx_q   <= cur;
      end
      if (cmd_i.final_emit) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // product and converted uptime; ticks * 1000 as ticks * (1024 - 16 - 8)
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= (ticks_ext << 10) - (ticks_ext << 4) - (ticks_ext << 3);
    end
    if (cmd_i.ms_latch) begin
      ms_q <= (tick_hz_q == '0) ? '0 : div_quot[TICK_W-1:0];
    end
  end

  // result register
  always_comb begin
    out_due_d  = 1'b1;
    out_idx_d  = TIDX_W'(pend_idx_q);
    out_last_d = 1'b0;
    if (cmd_i.final_emit) begin
      out_due_d  = pend_valid_q;
      out_idx_d  = pend_valid_q ? TIDX_W'(pend_idx_q) : '0;
      out_last_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_due_q   <= out_due_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
      out_ms_q    <= ms_q;
      out_ticks_q <= ticks_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.due_valid    = out_due_q;
  assign out_o.task_index   = out_idx_q;
  assign out_o.last         = out_last_q;
  assign out_o.msec_up      = out_ms_q;
  assign out_o.uptime_ticks = out_ticks_q;

  `PTD_ASSERT(a_out_load_free, out_load |-> out_free, "result overwritten before taken")
  `PTD_ASSERT(a_scan_bound, scan_q <= SCAN_W'(SLOTS), "scan index past table")

endmodule

`default_nettype wire

FILE: hw/rtl/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer for update, uptime conversion, run-pass scan and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ctrl import ptd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ptd_sts_t sts_i,
  output ptd_cmd_t      cmd_o
);

  ptd_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_MUL;
      S_MUL:    state_d = S_USTART;
      S_USTART: state_d = S_UWAIT;
      S_UWAIT: begin
        if (sts_i.div_done) begin
          state_d = (sts_i.kind == KIND_RUN) ? S_SCAN : S_FINAL;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_FINAL;
        end else if (sts_i.entry_due) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:   if (!sts_i.pend_valid || sts_i.out_free) state_d = S_REARM;
      S_REARM:  state_d = sts_i.per_zero ? S_SCAN : S_RWAIT;
      S_RWAIT:  if (sts_i.div_done) state_d = S_SCAN;
      S_FINAL:  if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_MUL:    cmd_o.mul = 1'b1;
      S_USTART: cmd_o.udiv_start = 1'b1;
      S_UWAIT:  cmd_o.ms_latch = sts_i.div_done;
      S_SCAN:   cmd_o.scan_inc = !sts_i.scan_end && !sts_i.entry_due;
      S_PUSH:   cmd_o.push = !sts_i.pend_valid || sts_i.out_free;
      S_REARM: begin
        cmd_o.rearm_zero = sts_i.per_zero;
        cmd_o.rdiv_start = !sts_i.per_zero;
      end
      S_RWAIT:  cmd_o.rearm_div = sts_i.div_done;
      S_FINAL:  cmd_o.final_emit = sts_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit
// Cooperative periodic task dispatcher: tick counter, task table, run passes.
// Tick, load and clear: the result is registered after the uptime conversion,
//   then the next item is taken (42-step serial divider for the conversion).
// Run pass: after the conversion each entry up to the scan limit is examined;
//   a due one is pushed, then re-armed (catch-up remainder from the same divider if period > 0).
// Reset (async, active low) zeroes counter, table, configuration, control state and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_dispatcher_unit import ptd_pkg::*; #(
  parameter int unsigned NUM_TASKS   = NUM_TASKS_DEF,
  parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ptd_in_if.sink                     in_i,
  ptd_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  ptd_cmd_t cmd;
  ptd_sts_t sts;
  logic     in_ready;

  // Controller: one item at a time; the result register lets the next item
  // in while the last result of the previous one still waits downstream.
  // A result that is not taken holds the scan or the final issue until it is.
  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: the item payload is consumed on the accept edge, so no copy
  // of it is held beyond the item kind.
  ptd_datapath #(
    .NUM_TASKS   (NUM_TASKS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_kind_i         (in_i.kind),
    .in_entry_index_i  (in_i.entry_index),
    .in_entry_period_i (in_i.entry_period),
    .in_entry_active_i (in_i.entry_active),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_o             (out_o)
  );

endmodule

`default_nettype wire
